// File: rtl/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 15;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int STAT_W     = 2;
	localparam int UN_W       = 16;

	localparam int DLT_W  = COORD_BITS + 1;
	localparam int NRM_W  = 2 * COORD_BITS + 4;
	localparam int NSQ_W  = 2 * NRM_W;
	localparam int DOT_W  = DLT_W + NRM_W + 3;
	localparam int OPW    = NSQ_W + 2;
	localparam int MAG_W  = OPW - 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int TSQ_W  = (2 * DOT_W > 2 * NRM_W + 2 * FRAC_BITS) ?
		2 * DOT_W : 2 * NRM_W + 2 * FRAC_BITS;
	localparam int U_W    = (2 * CFG_W > 2 * (FRAC_BITS + 1)) ? 2 * CFG_W : 2 * (FRAC_BITS + 1);
	localparam int Q_W    = FRAC_BITS + 1;
	localparam int BI_W   = $clog2(FRAC_BITS + 1);

	localparam int S_TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8;
	localparam int M_BITS    = 1 + STAT_W + 3 * UN_W;
	localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] CFG_TOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NML = 2'd1;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FEW  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_COLL = 2'd2;
	localparam logic [STAT_W-1:0] STAT_OFF  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_MUL_GO,
		S_MUL_WAIT,
		S_WB,
		S_NEXT,
		S_POST,
		S_FINAL,
		S_MINCHK,
		S_COMPINIT,
		S_COMPWR,
		S_OUT
	} state_t;

	typedef enum logic [4:0] {
		STP_X0, STP_X1, STP_X2, STP_X3, STP_X4, STP_X5,
		STP_S0, STP_S1, STP_S2,
		STP_D0, STP_D1, STP_D2,
		STP_DD, STP_TT, STP_TC,
		STP_MIN,
		STP_QT, STP_QC, STP_QM
	} step_t;

	typedef enum logic [3:0] {
		SRC_A0, SRC_A1, SRC_A2,
		SRC_B0, SRC_B1, SRC_B2,
		SRC_EC, SRC_NC, SRC_D, SRC_S, SRC_U,
		SRC_TOL, SRC_NML, SRC_CAND
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE,
		DST_N_SET, DST_N_SUB,
		DST_S_SET, DST_S_ADD,
		DST_D_SET, DST_D_ADD,
		DST_T_SET, DST_T_SHL,
		DST_U_SET,
		DST_OFF_CMP,
		DST_Q_CMP
	} dst_t;

	typedef struct packed {
		logic              in_ready;
		logic              mul_start;
		logic              wb;
		src_t              src_a;
		src_t              src_b;
		dst_t              dst;
		logic [1:0]        ci;
		logic [BI_W-1:0]   bi;
		logic              q_clr;
		logic              set_status;
		logic [STAT_W-1:0] status;
		logic              comp_wr;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic       in_acc;
		logic [1:0] pc;
		logic       last;
		logic       mul_done;
		logic       s_le_u;
		logic       off;
		logic       out_free;
	} sts_t;

endpackage

// File: rtl/pcc_mul.sv
`timescale 1ns / 1ps

module pcc_mul import pcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MAG_W-1:0]  a,
	input  logic [MAG_W-1:0]  b,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	logic              busy_q;
	logic [PROD_W-1:0] ar_q;
	logic [MAG_W-1:0]  br_q;
	logic [PROD_W-1:0] acc_q;

	assign done = busy_q && (br_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ar_q  <= PROD_W'(a);
			br_q  <= b;
			acc_q <= '0;
		end else if (busy_q && br_q != '0) begin
			if (br_q[0]) begin
				acc_q <= acc_q + ar_q;
			end
			ar_q <= ar_q << 1;
			br_q <= br_q >> 1;
		end
	end

endmodule

// File: rtl/pcc_datapath.sv
`timescale 1ns / 1ps

module pcc_datapath import pcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	localparam logic [Q_W-1:0] MAXQ = Q_W'((1 << FRAC_BITS) - 1);

	logic [CFG_W-1:0]             tol_q;
	logic [CFG_W-1:0]             nml_q;
	logic signed [COORD_BITS-1:0] hv_q [9];
	logic signed [COORD_BITS-1:0] cur_q [3];
	logic                         last_q;
	logic [1:0]                   vcnt_q;
	logic [1:0]                   pc_q;
	logic signed [NRM_W-1:0]      n_q [3];
	logic [NSQ_W-1:0]             s_q;
	logic signed [DOT_W-1:0]      d_q;
	logic [TSQ_W-1:0]             t_q;
	logic [U_W-1:0]               u_q;
	logic                         off_q;
	logic [Q_W-1:0]               q_q;
	logic                         msign_q;
	logic [STAT_W-1:0]            wst_q;
	logic [UN_W-1:0]              wcomp_q [3];
	logic                         ovalid_q;
	logic [STAT_W-1:0]            ost_q;
	logic [UN_W-1:0]              ocomp_q [3];

	logic                         accept;
	logic signed [COORD_BITS-1:0] in_c [3];
	logic signed [DLT_W-1:0]      a_w [3];
	logic signed [DLT_W-1:0]      b_w [3];
	logic signed [DLT_W-1:0]      e_w [3];
	logic [Q_W-1:0]               cand;
	logic signed [OPW-1:0]        opa;
	logic signed [OPW-1:0]        opb;
	logic [MAG_W-1:0]             ma;
	logic [MAG_W-1:0]             mb;
	logic                         mul_done;
	logic [PROD_W-1:0]            prod;
	logic signed [PROD_W:0]       rsg;
	logic                         cneg;
	logic [Q_W-1:0]               cmag;
	logic [UN_W-1:0]              cval;

	assign accept = s_tvalid && cmd.in_ready;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_c[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
			a_w[i]  = DLT_W'(hv_q[3+i]) - DLT_W'(hv_q[i]);
			b_w[i]  = DLT_W'(hv_q[6+i]) - DLT_W'(hv_q[i]);
			e_w[i]  = DLT_W'(cur_q[i]) - DLT_W'(hv_q[i]);
		end
	end

	assign cand = q_q | (Q_W'(1) << cmd.bi);

	function automatic logic signed [OPW-1:0] pick(input src_t src);
		logic signed [OPW-1:0] v;
		case (src)
			SRC_A0:   v = OPW'(a_w[0]);
			SRC_A1:   v = OPW'(a_w[1]);
			SRC_A2:   v = OPW'(a_w[2]);
			SRC_B0:   v = OPW'(b_w[0]);
			SRC_B1:   v = OPW'(b_w[1]);
			SRC_B2:   v = OPW'(b_w[2]);
			SRC_EC:   v = OPW'(e_w[cmd.ci]);
			SRC_NC:   v = OPW'(n_q[cmd.ci]);
			SRC_D:    v = OPW'(d_q);
			SRC_S:    v = OPW'($signed({1'b0, s_q}));
			SRC_U:    v = OPW'($signed({1'b0, u_q}));
			SRC_TOL:  v = OPW'($signed({1'b0, tol_q}));
			SRC_NML:  v = OPW'($signed({1'b0, nml_q}));
			SRC_CAND: v = OPW'($signed({1'b0, cand}));
			default:  v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa = pick(cmd.src_a);
		opb = pick(cmd.src_b);
	end

	assign ma  = MAG_W'(opa[OPW-1] ? -opa : opa);
	assign mb  = MAG_W'(opb[OPW-1] ? -opb : opb);

	pcc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (ma),
		.b      (mb),
		.done   (mul_done),
		.prod   (prod)
	);

	assign rsg = msign_q ? -$signed({1'b0, prod}) : $signed({1'b0, prod});

	assign cneg = n_q[cmd.ci][NRM_W-1];
	assign cmag = (!cneg && q_q > MAXQ) ? MAXQ : q_q;
	assign cval = cneg ? UN_W'(-{1'b0, cmag}) : UN_W'({1'b0, cmag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= CFG_W'(1);
			nml_q    <= CFG_W'(1);
			vcnt_q   <= 2'd0;
			off_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_addr == CFG_TOL) begin
				tol_q <= cfg_wdata;
			end
			if (cfg_we && cfg_addr == CFG_NML) begin
				nml_q <= cfg_wdata;
			end
			if (accept && vcnt_q != 2'd3) begin
				vcnt_q <= vcnt_q + 2'd1;
			end else if (cmd.out_load) begin
				vcnt_q <= 2'd0;
			end
			if (cmd.out_load) begin
				off_q <= 1'b0;
			end else if (cmd.wb && cmd.dst == DST_OFF_CMP && prod < PROD_W'(t_q)) begin
				off_q <= 1'b1;
			end
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pc_q   <= vcnt_q;
			last_q <= s_tlast;
			for (int i = 0; i < 3; i++) begin
				cur_q[i] <= in_c[i];
			end
			for (int k = 0; k < 9; k++) begin
				if (vcnt_q == 2'(k / 3)) begin
					hv_q[k] <= in_c[k % 3];
				end
			end
		end
		if (cmd.mul_start) begin
			msign_q <= opa[OPW-1] ^ opb[OPW-1];
		end
		if (cmd.wb) begin
			case (cmd.dst)
				DST_N_SET: n_q[cmd.ci] <= NRM_W'(rsg);
				DST_N_SUB: n_q[cmd.ci] <= n_q[cmd.ci] - NRM_W'(rsg);
				DST_S_SET: s_q <= NSQ_W'(prod);
				DST_S_ADD: s_q <= s_q + NSQ_W'(prod);
				DST_D_SET: d_q <= DOT_W'(rsg);
				DST_D_ADD: d_q <= d_q + DOT_W'(rsg);
				DST_T_SET: t_q <= TSQ_W'(prod);
				DST_T_SHL: t_q <= TSQ_W'(prod) << (2 * FRAC_BITS);
				DST_U_SET: u_q <= U_W'(prod);
				DST_Q_CMP: begin
					if (prod <= PROD_W'(t_q)) begin
						q_q <= cand;
					end
				end
				default: ;
			endcase
		end
		if (cmd.q_clr) begin
			q_q <= '0;
		end
		if (cmd.set_status) begin
			wst_q <= cmd.status;
			for (int i = 0; i < 3; i++) begin
				wcomp_q[i] <= '0;
			end
		end
		if (cmd.comp_wr) begin
			wcomp_q[cmd.ci] <= cval;
		end
		if (cmd.out_load) begin
			ost_q <= wst_q;
			for (int i = 0; i < 3; i++) begin
				ocomp_q[i] <= wcomp_q[i];
			end
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(M_TDATA_W - M_BITS){1'b0}}, ocomp_q[2], ocomp_q[1], ocomp_q[0],
		ost_q, (ost_q == STAT_OK)};

	assign sts.in_acc   = accept;
	assign sts.pc       = pc_q;
	assign sts.last     = last_q;
	assign sts.mul_done = mul_done;
	assign sts.s_le_u   = s_q <= NSQ_W'(u_q);
	assign sts.off      = off_q;
	assign sts.out_free = !ovalid_q || m_tready;

endmodule

// File: rtl/pcc_ctrl.sv
`timescale 1ns / 1ps

module pcc_ctrl import pcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t          state_q, state_d;
	step_t           step_q, step_d;
	logic [1:0]      ci_q, ci_d;
	logic [BI_W-1:0] bi_q, bi_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= STP_X0;
			ci_q    <= 2'd0;
			bi_q    <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			ci_q    <= ci_d;
			bi_q    <= bi_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		ci_d    = ci_q;
		bi_d    = bi_q;
		case (state_q)
			S_IDLE: begin
				if (sts.in_acc) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				ci_d = 2'd0;
				if (sts.pc == 2'd2) begin
					step_d  = STP_X0;
					state_d = S_MUL_GO;
				end else if (sts.pc == 2'd3) begin
					step_d  = STP_D0;
					state_d = S_MUL_GO;
				end else begin
					state_d = S_POST;
				end
			end
			S_MUL_GO:   state_d = S_MUL_WAIT;
			S_MUL_WAIT: begin
				if (sts.mul_done) begin
					state_d = S_WB;
				end
			end
			S_WB:       state_d = S_NEXT;
			S_NEXT: begin
				state_d = S_MUL_GO;
				case (step_q)
					STP_X0: step_d = STP_X1;
					STP_X1: begin step_d = STP_X2; ci_d = 2'd1; end
					STP_X2: step_d = STP_X3;
					STP_X3: begin step_d = STP_X4; ci_d = 2'd2; end
					STP_X4: step_d = STP_X5;
					STP_X5: begin step_d = STP_S0; ci_d = 2'd0; end
					STP_S0: begin step_d = STP_S1; ci_d = 2'd1; end
					STP_S1: begin step_d = STP_S2; ci_d = 2'd2; end
					STP_S2: state_d = S_POST;
					STP_D0: begin step_d = STP_D1; ci_d = 2'd1; end
					STP_D1: begin step_d = STP_D2; ci_d = 2'd2; end
					STP_D2: step_d = STP_DD;
					STP_DD: step_d = STP_TT;
					STP_TT: step_d = STP_TC;
					STP_TC: state_d = S_POST;
					STP_MIN: state_d = S_MINCHK;
					STP_QT: step_d = STP_QC;
					STP_QC: step_d = STP_QM;
					STP_QM: begin
						if (bi_q == '0) begin
							state_d = S_COMPWR;
						end else begin
							bi_d   = bi_q - BI_W'(1);
							step_d = STP_QC;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_POST: state_d = sts.last ? S_FINAL : S_IDLE;
			S_FINAL: begin
				if (sts.pc < 2'd2) begin
					state_d = S_OUT;
				end else begin
					step_d  = STP_MIN;
					state_d = S_MUL_GO;
				end
			end
			S_MINCHK: begin
				ci_d    = 2'd0;
				state_d = sts.s_le_u ? S_OUT : S_COMPINIT;
			end
			S_COMPINIT: begin
				step_d  = STP_QT;
				bi_d    = BI_W'(FRAC_BITS);
				state_d = S_MUL_GO;
			end
			S_COMPWR: begin
				if (ci_q == 2'd2) begin
					state_d = S_OUT;
				end else begin
					ci_d    = ci_q + 2'd1;
					state_d = S_COMPINIT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.ci    = ci_q;
		cmd.bi    = bi_q;
		cmd.src_a = SRC_A0;
		cmd.src_b = SRC_B0;
		cmd.dst   = DST_NONE;
		case (step_q)
			STP_X0:  begin cmd.src_a = SRC_A1; cmd.src_b = SRC_B2; cmd.dst = DST_N_SET; end
			STP_X1:  begin cmd.src_a = SRC_A2; cmd.src_b = SRC_B1; cmd.dst = DST_N_SUB; end
			STP_X2:  begin cmd.src_a = SRC_A2; cmd.src_b = SRC_B0; cmd.dst = DST_N_SET; end
			STP_X3:  begin cmd.src_a = SRC_A0; cmd.src_b = SRC_B2; cmd.dst = DST_N_SUB; end
			STP_X4:  begin cmd.src_a = SRC_A0; cmd.src_b = SRC_B1; cmd.dst = DST_N_SET; end
			STP_X5:  begin cmd.src_a = SRC_A1; cmd.src_b = SRC_B0; cmd.dst = DST_N_SUB; end
			STP_S0:  begin cmd.src_a = SRC_NC; cmd.src_b = SRC_NC; cmd.dst = DST_S_SET; end
			STP_S1,
			STP_S2:  begin cmd.src_a = SRC_NC; cmd.src_b = SRC_NC; cmd.dst = DST_S_ADD; end
			STP_D0:  begin cmd.src_a = SRC_NC; cmd.src_b = SRC_EC; cmd.dst = DST_D_SET; end
			STP_D1,
			STP_D2:  begin cmd.src_a = SRC_NC; cmd.src_b = SRC_EC; cmd.dst = DST_D_ADD; end
			STP_DD:  begin cmd.src_a = SRC_D; cmd.src_b = SRC_D; cmd.dst = DST_T_SET; end
			STP_TT:  begin cmd.src_a = SRC_TOL; cmd.src_b = SRC_TOL; cmd.dst = DST_U_SET; end
			STP_TC:  begin cmd.src_a = SRC_S; cmd.src_b = SRC_U; cmd.dst = DST_OFF_CMP; end
			STP_MIN: begin cmd.src_a = SRC_NML; cmd.src_b = SRC_NML; cmd.dst = DST_U_SET; end
			STP_QT:  begin cmd.src_a = SRC_NC; cmd.src_b = SRC_NC; cmd.dst = DST_T_SHL; end
			STP_QC:  begin cmd.src_a = SRC_CAND; cmd.src_b = SRC_CAND; cmd.dst = DST_U_SET; end
			STP_QM:  begin cmd.src_a = SRC_S; cmd.src_b = SRC_U; cmd.dst = DST_Q_CMP; end
			default: ;
		endcase
		case (state_q)
			S_IDLE:     cmd.in_ready = 1'b1;
			S_MUL_GO:   cmd.mul_start = 1'b1;
			S_WB:       cmd.wb = 1'b1;
			S_FINAL: begin
				cmd.set_status = sts.pc < 2'd2;
				cmd.status     = STAT_FEW;
			end
			S_MINCHK: begin
				cmd.set_status = 1'b1;
				cmd.status     = sts.s_le_u ? STAT_COLL : (sts.off ? STAT_OFF : STAT_OK);
			end
			S_COMPINIT: cmd.q_clr = 1'b1;
			S_COMPWR:   cmd.comp_wr = 1'b1;
			S_OUT:      cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// File: rtl/polygon_coplanarity_check_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Transaction
// s_*       in         one vertex: coord_x, coord_y, coord_z, last_point on s_tlast
// m_*       out        one verdict per polygon: is_coplanar, check_status, unit normal
// cfg_*     in         register write, index 0 plane_tolerance, 1 normal_min_length
//
// All arithmetic runs through one shift-and-add multiplier that retires one bit of
// its second operand per cycle. The first two vertices are only stored, the third
// forms the plane normal, later ones test their offset against the tolerance, and a
// closing vertex adds the three unit normal searches.
// Reset is asynchronous, active low, and needs no clearing pass.
// The result register lets the next polygon start while a verdict waits on m_tready.

module polygon_coplanarity_check_top import pcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// coord_x, coord_y, coord_z
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// is_coplanar, check_status, unit_normal_x, unit_normal_y, unit_normal_z
	output logic [M_TDATA_W-1:0] m_tdata
);

	cmd_t cmd;
	sts_t sts;

	pcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	pcc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign s_tready = cmd.in_ready;

endmodule

// File: rtl/pcc_checker.sv
`timescale 1ns / 1ps

module pcc_checker import pcc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	a_flag_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] == (m_tdata[2:1] == STAT_OK))
		else $error("coplanar flag disagrees with status");

	a_zero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:1] == STAT_FEW || m_tdata[2:1] == STAT_COLL)
		|-> m_tdata[50:3] == '0)
		else $error("normal not zero for degenerate polygon");

endmodule

bind polygon_coplanarity_check_top pcc_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
